// ===== sv/gaas_pkg.sv =====
package gaas_pkg;

   // Number of vectoring iterations in each CORDIC chain.
   localparam int CORDIC_STEPS = 32;
   localparam int TAB_LEN      = 40;
   localparam int GUARD_BITS   = 16;

   // Converged CORDIC gain in Q30 and the shift that brings z to the guard scale.
   localparam logic signed [63:0] GAIN_Q30 = 64'sd1768195363;
   localparam int GAIN_SHIFT = 30 - GUARD_BITS;

   localparam int CW = 56;   // CORDIC coordinate width
   localparam int AW = 34;   // CORDIC angle accumulator width

   localparam logic signed [AW-1:0] QUARTER_TURN = AW'(64'sd1073741824);

   // round(atan(2^-i) * 2^31 / pi)
   localparam logic signed [AW-1:0] ATAN_TAB [TAB_LEN] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
      34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
      34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
      34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
      34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
      34'sd652,       34'sd326,       34'sd163,       34'sd81,
      34'sd41,        34'sd20,        34'sd10,        34'sd5,
      34'sd3,         34'sd1,         34'sd1,         34'sd0,
      34'sd0,         34'sd0,         34'sd0,         34'sd0,
      34'sd0,         34'sd0,         34'sd0,         34'sd0
   };

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_X_SHIFT    = 3'd0,
      REG_Y_SHIFT    = 3'd1,
      REG_Z_SHIFT    = 3'd2,
      REG_YAW_TRIM   = 3'd3,
      REG_PITCH_TRIM = 3'd4
   } reg_index_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_SRC_BAD    = 3'd1,
      ST_RAW_ZERO   = 3'd2,
      ST_OVERFLOW   = 3'd3,
      ST_SHIFT_ZERO = 3'd4
   } status_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [AW-1:0] a;
   } cvec_type;

   typedef struct packed {
      logic                 vld;
      status_type           st;
      logic signed [31:0]   xa;
      logic signed [31:0]   ya;
      logic signed [31:0]   za;
      logic signed [31:0]   zr;
      logic signed [CW-1:0] zpr;
      logic signed [CW-1:0] zps;
      logic signed [AW-1:0] yaw_r;
      logic signed [AW-1:0] yaw_s;
      cvec_type             lr;
      cvec_type             ls;
   } stage_type;

   // A vector in the left half plane is first turned by a quarter turn.
   function automatic cvec_type cordic_pre(cvec_type v);
      cvec_type r;
      r = v;
      if (v.x < 0) begin
         if (v.y >= 0) begin
            r.x = v.y;
            r.y = -v.x;
            r.a = v.a + QUARTER_TURN;
         end else begin
            r.x = -v.y;
            r.y = v.x;
            r.a = v.a - QUARTER_TURN;
         end
      end
      return r;
   endfunction

   // One vectoring micro-rotation with floor shifts.
   function automatic cvec_type cordic_iter(cvec_type v, logic [5:0] sh);
      cvec_type             r;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      dx = v.y >>> sh;
      dy = v.x >>> sh;
      r  = v;
      if (v.y > 0) begin
         r.x = v.x + dx;
         r.y = v.y - dy;
         r.a = v.a + ATAN_TAB[sh];
      end else begin
         r.x = v.x - dx;
         r.y = v.y + dy;
         r.a = v.a - ATAN_TAB[sh];
      end
      return r;
   endfunction

   // z scaled by the CORDIC gain to the guard-bit scale, floor shift.
   function automatic logic signed [CW-1:0] gain_scale(logic signed [31:0] z);
      logic signed [63:0] p;
      p = 64'(z) * GAIN_Q30;
      return CW'(p >>> GAIN_SHIFT);
   endfunction

endpackage

// ===== sv/gimbal_aim_angle_solver_top.sv =====
// Channel   | Direction | Beat contents
// ----------+-----------+--------------------------------------------------------
// req_      | in        | tuser: source_ok; tdata: x_pos, y_pos, z_pos
// rsp_      | out       | tuser: ok, status; tdata: yaw_geo, pitch_geo, x_adj,
//           |           |   y_adj, z_adj, yaw_aim, pitch_aim, zero pad
// csr_      | in        | write enable, register index, 32-bit write data
//
// One beat is accepted per cycle while the result side does not stall, and each
// beat gives one result beat. The pipeline length is set by the two chained
// CORDIC pipelines, one stage per micro-rotation.
// Reset is synchronous and clears the valid bits of every stage and the
// configuration registers. A stall on the result side freezes the whole
// pipeline in place, so nothing is lost or repeated; req_tready follows it.
module gimbal_aim_angle_solver_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // x_pos[31:0], y_pos[63:32], z_pos[95:64]
   input  logic         req_tuser,   // source_ok
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [231:0] rsp_tdata,   // yaw_geo, pitch_geo, x_adj, y_adj, z_adj,
                                     // yaw_aim (32 each), pitch_aim (33), pad
   output logic [3:0]   rsp_tuser,   // ok[0], status[3:1]
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   localparam int S  = gaas_pkg::CORDIC_STEPS;
   localparam int NS = 2 * S + 3;   // pipeline stages before the output register
   localparam int CW = gaas_pkg::CW;
   localparam int AW = gaas_pkg::AW;

   // Configuration registers.
   logic signed [31:0] x_shift_ff, y_shift_ff, z_shift_ff, yaw_trim_ff, pitch_trim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_shift_ff    <= '0;
         y_shift_ff    <= '0;
         z_shift_ff    <= '0;
         yaw_trim_ff   <= '0;
         pitch_trim_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            gaas_pkg::REG_X_SHIFT:    x_shift_ff    <= csr_wdata;
            gaas_pkg::REG_Y_SHIFT:    y_shift_ff    <= csr_wdata;
            gaas_pkg::REG_Z_SHIFT:    z_shift_ff    <= csr_wdata;
            gaas_pkg::REG_YAW_TRIM:   yaw_trim_ff   <= csr_wdata;
            gaas_pkg::REG_PITCH_TRIM: pitch_trim_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   gaas_pkg::stage_type pipe_ff [NS];
   gaas_pkg::stage_type pipe_in [NS];

   logic         out_vld_ff;
   logic [231:0] out_data_ff, out_data_in;
   logic [3:0]   out_user_ff, out_user_in;
   logic         adv;

   // The whole pipeline moves whenever the output register can take a beat.
   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   // Stage 0: shifted coordinates, range checks and status.
   logic signed [31:0] x_pos, y_pos, z_pos;
   logic signed [32:0] xa_w, ya_w, za_w;
   logic               ovf;

   assign x_pos = req_tdata[31:0];
   assign y_pos = req_tdata[63:32];
   assign z_pos = req_tdata[95:64];

   always_comb begin
      xa_w = 33'(x_pos) + 33'(x_shift_ff);
      ya_w = 33'(y_pos) + 33'(y_shift_ff);
      za_w = 33'(z_pos) + 33'(z_shift_ff);
      ovf  = (xa_w[32] != xa_w[31]) || (ya_w[32] != ya_w[31]) || (za_w[32] != za_w[31]);
      pipe_in[0]     = '0;
      pipe_in[0].vld = req_tvalid;
      pipe_in[0].xa  = xa_w[31:0];
      pipe_in[0].ya  = ya_w[31:0];
      pipe_in[0].za  = za_w[31:0];
      pipe_in[0].zr  = z_pos;
      priority if (!req_tuser) begin
         pipe_in[0].st = gaas_pkg::ST_SRC_BAD;
      end else if (x_pos == 0 && y_pos == 0) begin
         pipe_in[0].st = gaas_pkg::ST_RAW_ZERO;
      end else if (ovf) begin
         pipe_in[0].st = gaas_pkg::ST_OVERFLOW;
      end else if (xa_w == 0 && ya_w == 0) begin
         pipe_in[0].st = gaas_pkg::ST_SHIFT_ZERO;
      end else begin
         pipe_in[0].st = gaas_pkg::ST_OK;
      end
      // Coordinates move to the guard-bit scale for the yaw chains.
      pipe_in[0].lr.x = CW'(x_pos) <<< gaas_pkg::GUARD_BITS;
      pipe_in[0].lr.y = CW'(y_pos) <<< gaas_pkg::GUARD_BITS;
      pipe_in[0].ls.x = CW'($signed(xa_w[31:0])) <<< gaas_pkg::GUARD_BITS;
      pipe_in[0].ls.y = CW'($signed(ya_w[31:0])) <<< gaas_pkg::GUARD_BITS;
   end

   // Stage 1: gain-scaled z for both points and the quarter-turn pre-rotation.
   always_comb begin
      pipe_in[1]     = pipe_ff[0];
      pipe_in[1].zpr = gaas_pkg::gain_scale(pipe_ff[0].zr);
      pipe_in[1].zps = gaas_pkg::gain_scale(pipe_ff[0].za);
      pipe_in[1].lr  = gaas_pkg::cordic_pre(pipe_ff[0].lr);
      pipe_in[1].ls  = gaas_pkg::cordic_pre(pipe_ff[0].ls);
   end

   // Yaw chains: one micro-rotation per stage for the raw and shifted points.
   for (genvar k = 2; k < S + 2; k++) begin : g_yaw
      always_comb begin
         pipe_in[k]    = pipe_ff[k-1];
         pipe_in[k].lr = gaas_pkg::cordic_iter(pipe_ff[k-1].lr, 6'(k - 2));
         pipe_in[k].ls = gaas_pkg::cordic_iter(pipe_ff[k-1].ls, 6'(k - 2));
      end
   end

   // Hand-over stage: keep the yaw angles, start pitch from (magnitude, z).
   always_comb begin
      gaas_pkg::cvec_type vr, vs;
      vr.x = pipe_ff[S+1].lr.x;
      vr.y = pipe_ff[S+1].zpr;
      vr.a = '0;
      vs.x = pipe_ff[S+1].ls.x;
      vs.y = pipe_ff[S+1].zps;
      vs.a = '0;
      pipe_in[S+2]       = pipe_ff[S+1];
      pipe_in[S+2].yaw_r = pipe_ff[S+1].lr.a;
      pipe_in[S+2].yaw_s = pipe_ff[S+1].ls.a;
      pipe_in[S+2].lr    = gaas_pkg::cordic_pre(vr);
      pipe_in[S+2].ls    = gaas_pkg::cordic_pre(vs);
   end

   // Pitch chains.
   for (genvar k = S + 3; k < NS; k++) begin : g_pitch
      always_comb begin
         pipe_in[k]    = pipe_ff[k-1];
         pipe_in[k].lr = gaas_pkg::cordic_iter(pipe_ff[k-1].lr, 6'(k - S - 3));
         pipe_in[k].ls = gaas_pkg::cordic_iter(pipe_ff[k-1].ls, 6'(k - S - 3));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            pipe_ff[i] <= '0;
         end
      end else if (adv) begin
         for (int i = 0; i < NS; i++) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   // Output stage: trims, yaw wrap by truncation, zeroed fields on failure.
   always_comb begin
      logic signed [AW-1:0] yaw_c, pitch_c;
      yaw_c   = pipe_ff[NS-1].yaw_s + AW'(yaw_trim_ff);
      pitch_c = pipe_ff[NS-1].ls.a + AW'(pitch_trim_ff);
      out_data_in = '0;
      out_user_in = {pipe_ff[NS-1].st, 1'b0};
      if (pipe_ff[NS-1].st == gaas_pkg::ST_OK) begin
         out_user_in[0]         = 1'b1;
         out_data_in[31:0]      = pipe_ff[NS-1].yaw_r[31:0];
         out_data_in[63:32]     = pipe_ff[NS-1].lr.a[31:0];
         out_data_in[95:64]     = pipe_ff[NS-1].xa;
         out_data_in[127:96]    = pipe_ff[NS-1].ya;
         out_data_in[159:128]   = pipe_ff[NS-1].za;
         out_data_in[191:160]   = yaw_c[31:0];
         out_data_in[224:192]   = pitch_c[32:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= pipe_ff[NS-1].vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
      end
   end

endmodule
